// File: rtl/battery_charge_gauge_macros.svh
// Assertion macros used by the battery charge gauge top level.
`ifndef BATTERY_CHARGE_GAUGE_MACROS_SVH
`define BATTERY_CHARGE_GAUGE_MACROS_SVH

// Generic clocked check, disabled while reset is asserted.
`define BCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that applies whenever the output holds a transaction.
`define BCG_ASSERT_OUT(lbl, cond, msg) \
  `BCG_ASSERT(lbl, m_axis_tvalid_o |-> (cond), msg)

`endif

// File: rtl/bcg_pkg.sv
// Shared types and constants of the battery charge gauge.
package bcg_pkg;

  localparam int unsigned MV_W    = 14;  // pack millivolts
  localparam int unsigned PCT_W   = 7;   // percent, also threshold
  localparam int unsigned V_W     = 12;  // divider-node millivolts, 0..3300
  localparam int unsigned VREF_MV = 3300;
  localparam int unsigned D_W     = 10;  // offset into a segment, 0..600
  localparam int unsigned SH_W    = 2;

  localparam logic [PCT_W-1:0] THR_RESET = 7'd5;

  // floor(z/10) == (z*RECIP10)>>16 for z <= 9900
  localparam int unsigned RECIP10 = 6554;
  // floor(d/15) == (d*RECIP15)>>16 for d <= 600
  localparam int unsigned RECIP15 = 4370;

  localparam int unsigned TBL_LEN = 9;
  localparam int unsigned SEG_CNT = TBL_LEN - 1;

  localparam logic [MV_W-1:0] TABLE_MV [TBL_LEN] = '{
    14'd12600, 14'd12300, 14'd11700, 14'd11400, 14'd11100,
    14'd10800, 14'd10500, 14'd9900,  14'd9600
  };
  localparam logic [PCT_W-1:0] TABLE_PCT [TBL_LEN] = '{
    7'd100, 7'd90, 7'd70, 7'd60, 7'd40, 7'd20, 7'd10, 7'd5, 7'd0
  };
  // Each segment slope dp/dv reduces to 1/(15 << shift).
  localparam logic [SH_W-1:0] SEG_SHIFT [SEG_CNT] = '{
    2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd3, 2'd2
  };

  typedef struct packed {
    logic [PCT_W-1:0] pl;  // percent at segment base
    logic [D_W-1:0]   d;   // mv above segment base
    logic [SH_W-1:0]  sh;  // slope shift
  } seg_t;

  // Packed to match tdata: mv lowest, then pct, then flag.
  typedef struct packed {
    logic             low_battery;
    logic [PCT_W-1:0] charge_pct;
    logic [MV_W-1:0]  battery_mv;
  } result_t;

endpackage

// File: rtl/bcg_mv.sv
// Count to pack millivolt pipeline: scale, divide by full scale, divider ratio.
module bcg_mv #(
  parameter int unsigned AdcBits = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [AdcBits-1:0]        count_i,
  output logic                      valid_o,
  output logic [bcg_pkg::MV_W-1:0]  mv_o
);
  import bcg_pkg::*;

  localparam int unsigned XW = AdcBits + V_W;   // count * 3300
  localparam int unsigned QW = V_W + 1;         // quotient estimate
  localparam logic [XW-1:0] FullScale = XW'((64'd1 << AdcBits) - 64'd1);

  logic [3:0]          vld_q;
  logic [XW-1:0]       x1_q, x2_q;
  logic [QW-1:0]       q1_q;
  logic [V_W-1:0]      v_q;
  logic [MV_W-1:0]     mv_q;

  logic [XW:0]         sum;
  logic [XW-1:0]       q1m, rem;
  logic [V_W-1:0]      v_d;
  logic [MV_W-1:0]     v3;
  logic [MV_W+12:0]    prod;
  logic [MV_W-1:0]     mv_d;

  // q1 = (x + x>>N) >> N is x/(2^N-1) or one short of it
  assign sum  = {1'b0, x1_q} + (XW + 1)'(x1_q >> AdcBits);
  assign q1m  = XW'({q1_q, {AdcBits{1'b0}}}) - XW'(q1_q);
  assign rem  = x2_q - q1m;
  assign v_d  = V_W'(q1_q) + V_W'(rem >= FullScale);

  // mv = 4v + floor(3v/10)
  assign v3   = MV_W'({v_q, 1'b0}) + MV_W'(v_q);
  assign prod = (MV_W + 13)'(v3) * (MV_W + 13)'(RECIP10);
  assign mv_d = {v_q, 2'b00} + MV_W'(prod[MV_W+12:16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q <= XW'(count_i) * XW'(VREF_MV);
      x2_q <= x1_q;
      q1_q <= sum[XW:AdcBits];
      v_q  <= v_d;
      mv_q <= mv_d;
    end
  end

  assign valid_o = vld_q[3];
  assign mv_o    = mv_q;

endmodule

// File: rtl/bcg_pct.sv
// Millivolt to percent: segment lookup stage, then slope and threshold compare.
module bcg_pct (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [bcg_pkg::MV_W-1:0]  mv_i,
  input  logic [bcg_pkg::PCT_W-1:0] thr_i,
  output logic                      valid_o,
  output bcg_pkg::result_t          res_o
);
  import bcg_pkg::*;

  logic            vld_q;
  seg_t            seg_d, seg_q;
  logic [MV_W-1:0] mv_q;
  logic [22:0]     prod;
  logic [PCT_W-1:0] step, pct;

  // Lowest-index segment wins on a breakpoint; saturation uses d = 0.
  always_comb begin
    seg_d = '0;
    if (mv_i >= TABLE_MV[0]) begin
      seg_d.pl = TABLE_PCT[0];
    end else if (mv_i > TABLE_MV[TBL_LEN-1]) begin
      for (int i = SEG_CNT - 1; i >= 0; i--) begin
        if (mv_i <= TABLE_MV[i] && mv_i >= TABLE_MV[i+1]) begin
          seg_d.pl = TABLE_PCT[i+1];
          seg_d.d  = D_W'(mv_i - TABLE_MV[i+1]);
          seg_d.sh = SEG_SHIFT[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_q <= seg_d;
      mv_q  <= mv_i;
    end
  end

  // floor(d/15) >> sh == floor(d/(15 << sh))
  assign prod = 23'(seg_q.d) * 23'(RECIP15);
  assign step = prod[22:16] >> seg_q.sh;
  assign pct  = seg_q.pl + step;

  assign valid_o           = vld_q;
  assign res_o.battery_mv  = mv_q;
  assign res_o.charge_pct  = pct;
  assign res_o.low_battery = pct < thr_i;

endmodule

// File: rtl/bcg_skid.sv
// Output register with a spare entry so upstream ready is registered.
module bcg_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bcg_pkg::result_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bcg_pkg::result_t out_data_o
);
  import bcg_pkg::*;

  logic    out_vld_q, spare_vld_q;
  result_t out_q, spare_q;
  logic    hold;

  assign hold       = out_vld_q && !out_ready_i;
  assign in_ready_o = !spare_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      spare_vld_q <= 1'b0;
    end else if (hold) begin
      if (in_valid_i && in_ready_o) begin
        spare_vld_q <= 1'b1;
      end
    end else if (spare_vld_q) begin
      out_vld_q   <= 1'b1;
      spare_vld_q <= 1'b0;
    end else begin
      out_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold) begin
      if (in_valid_i && in_ready_o) begin
        spare_q <= in_data_i;
      end
    end else if (spare_vld_q) begin
      out_q <= spare_q;
    end else begin
      out_q <= in_data_i;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/battery_charge_gauge.sv
// Battery charge gauge: ADC count to pack mV, state of charge and low-battery flag.
// Path: the input transaction passes 4 mV stages, one segment stage, then the output
//   register before its result appears on m_axis.
// Throughput: one transaction per cycle; the pipeline advances as a whole and only
//   stops when the output register and its spare entry are both full.
// Reset (rst_ni, async, low): pipeline and output emptied, threshold back to 5 %.
module battery_charge_gauge #(
  parameter int unsigned AdcBits = 12   // 8..16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [((AdcBits+7)/8)*8-1:0]  s_axis_tdata_i,   // [AdcBits-1:0] avg_count
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [23:0]                   m_axis_tdata_o,   // battery_mv[13:0],
                                                          // charge_pct[20:14],
                                                          // low_battery[21]
  // threshold register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bcg_pkg::PCT_W-1:0]     cfg_data_i        // low_threshold_pct
);
  import bcg_pkg::*;

  `include "battery_charge_gauge_macros.svh"

  logic [PCT_W-1:0] thr_q;
  logic             adv;       // whole pipeline moves one stage
  logic             mv_vld;
  logic [MV_W-1:0]  mv;
  logic             res_vld;
  result_t          res, out_res;

  // Threshold is always writable; callers write it only while the gauge is idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Skid ready is a flop output, so this does not path back from m_axis_tready_i.
  assign s_axis_tready_o = adv;

  bcg_mv #(
    .AdcBits (AdcBits)
  ) u_mv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid_i),
    .count_i (s_axis_tdata_i[AdcBits-1:0]),
    .valid_o (mv_vld),
    .mv_o    (mv)
  );

  bcg_pct u_pct (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (mv_vld),
    .mv_i    (mv),
    .thr_i   (thr_q),
    .valid_o (res_vld),
    .res_o   (res)
  );

  bcg_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_vld),
    .in_ready_o  (adv),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata_o = {2'b00, out_res};

  // ---- checks ----
  `BCG_ASSERT_OUT(a_pct_range, out_res.charge_pct <= 7'd100, "charge_pct above 100")
  `BCG_ASSERT_OUT(a_mv_range, out_res.battery_mv <= 14'd14190, "battery_mv out of range")
  `BCG_ASSERT_OUT(a_low_flag, out_res.low_battery == (out_res.charge_pct < thr_q),
                  "low_battery disagrees with threshold")
  `BCG_ASSERT(a_stall_src, !s_axis_tready_o |-> m_axis_tvalid_o,
              "input stalled with empty output register")

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for battery_charge_gauge: count to mV, percent and low flag.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bcg_pkg::*;

  localparam int unsigned RUN_LIMIT  = 200000;  // cycles before the run is declared hung
  localparam int unsigned DRAIN_WAIT = 20;      // extra cycles after the last result
  localparam int unsigned KNEES      = 9;
  localparam logic [PCT_W-1:0] THR_MAX = 7'd127;

  // Discharge curve, highest voltage first.
  localparam int unsigned KNEE_MV  [KNEES] = '{12600, 12300, 11700, 11400, 11100,
                                               10800, 10500, 9900, 9600};
  localparam int unsigned KNEE_PCT [KNEES] = '{100, 90, 70, 60, 40, 20, 10, 5, 0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;   // [11:0] avg_count
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;        // [13:0] battery_mv, [20:14] charge_pct, [21] low_battery
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [PCT_W-1:0] cfg_data_i = '0;  // low_threshold_pct

  battery_charge_gauge #(.AdcBits(12)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // Predicts each reading from the accepted count and checks results in order.
  class gauge_scoreboard;
    result_t          expected_readings[$];
    logic [PCT_W-1:0] threshold;
    int unsigned      error_count;

    function new();
      threshold   = THR_RESET;
      error_count = 0;
    endfunction

    function int unsigned pack_mv(logic [11:0] count);
      int unsigned node_mv;
      node_mv = (int'(count) * 3300) / 4095;  // divider node, truncated
      return (node_mv * 43) / 10;             // scale up to the pack
    endfunction

    function int unsigned charge_of(int unsigned mv);
      int unsigned pct;
      bit          found;
      pct   = 0;
      found = 1'b0;
      if (mv >= KNEE_MV[0]) begin
        pct = KNEE_PCT[0];
      end else if (mv <= KNEE_MV[KNEES-1]) begin
        pct = KNEE_PCT[KNEES-1];
      end else begin
        // upper segment wins when mv sits on a knee
        for (int i = 0; i < KNEES - 1; i++) begin
          if (!found && mv <= KNEE_MV[i] && mv >= KNEE_MV[i+1]) begin
            found = 1'b1;
            pct = KNEE_PCT[i+1] + ((mv - KNEE_MV[i+1]) * (KNEE_PCT[i] - KNEE_PCT[i+1]))
                                  / (KNEE_MV[i] - KNEE_MV[i+1]);
          end
        end
      end
      return pct;
    endfunction

    function result_t predict_reading(logic [11:0] count);
      result_t     r;
      int unsigned mv;
      int unsigned pct;
      mv  = pack_mv(count);
      pct = charge_of(mv);
      r.battery_mv  = mv[MV_W-1:0];
      r.charge_pct  = pct[PCT_W-1:0];
      r.low_battery = (pct < threshold);
      return r;
    endfunction

    function void note_sample(logic [11:0] count);
      expected_readings.push_back(predict_reading(count));
    endfunction

    function void check_reading(logic [23:0] tdata);
      result_t want;
      result_t got;
      got = tdata[21:0];
      if (expected_readings.size() == 0) begin
        $error("unexpected result transaction, tdata=%h", tdata);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        if (got.battery_mv !== want.battery_mv) begin
          $error("battery_mv: expected %0d, got %0d", want.battery_mv, got.battery_mv);
          error_count++;
        end
        if (got.charge_pct !== want.charge_pct) begin
          $error("charge_pct: expected %0d, got %0d", want.charge_pct, got.charge_pct);
          error_count++;
        end
        if (got.low_battery !== want.low_battery) begin
          $error("low_battery: expected %0d, got %0d", want.low_battery, got.low_battery);
          error_count++;
        end
      end
    endfunction
  endclass

  gauge_scoreboard gauge_sb = new();
  int unsigned     idle_pct = 25;  // odds of an idle burst: per output cycle, per input sample
  int unsigned     cycle_count = 0;
  logic [11:0]     knee_count [KNEES];  // first count that reaches each knee

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog and transaction monitor. Sampled at the rising edge, before NBA updates.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      gauge_sb.note_sample(s_axis_tdata_i[11:0]);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      gauge_sb.check_reading(m_axis_tdata_o);
  end

  // Result side back-pressure: ready drops in bursts of random length.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) >= idle_pct) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end
    end
  end

  task automatic send_sample(logic [11:0] count);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, count};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (gauge_sb.expected_readings.size() != 0) @(posedge clk_i);
  endtask

  // Only called with the pipeline empty.
  task automatic write_threshold(logic [PCT_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    gauge_sb.threshold = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [11:0] pick_count();
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(0, 9);
    k   = $urandom_range(0, KNEES - 1);
    if (sel < 6) return 12'($urandom_range(2700, 3700));  // covers the curve and past both ends
    if (sel < 9) return 12'($urandom_range(0, 4095));
    return knee_count[k] + 12'($urandom_range(0, 2)) - 12'd1;  // straddle a knee
  endfunction

  initial begin
    logic [PCT_W-1:0] phase_thr [5];
    int unsigned      phase_idle [5];
    int unsigned      k;

    // Locate the knees in count space for the directed part.
    k = 0;
    for (int c = 0; c < 4096; c++) begin
      while (k < KNEES && gauge_sb.pack_mv(12'(c)) >= KNEE_MV[KNEES-1-k]) begin
        knee_count[KNEES-1-k] = 12'(c);
        k++;
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, bit patterns, and both sides of each knee.
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd1);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'h800);
    send_sample(12'h7FF);
    for (int i = 0; i < KNEES; i++) begin
      send_sample(knee_count[i]);
      send_sample(knee_count[i] - 12'd1);
    end
    wait_drained();

    // Threshold extremes first, then ordinary values; the last phase runs without idling.
    phase_thr  = '{7'd0, THR_MAX, 7'd100, 7'd101, 7'($urandom_range(1, 99))};
    phase_idle = '{40, 0, 60, 15, 0};
    for (int p = 0; p < 5; p++) begin
      write_threshold(phase_thr[p]);
      idle_pct = phase_idle[p];
      repeat (80) send_sample(pick_count());
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (gauge_sb.error_count == 0 && gauge_sb.expected_readings.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bcg_pkg.sv
rtl/bcg_mv.sv
rtl/bcg_pct.sv
rtl/bcg_skid.sv
rtl/battery_charge_gauge.sv
tb/sv/tb_top.sv
